[design/source_text_tokenizer_unit_assert.svh]
// Assertion macros shared by the tokenizer modules.
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tokenizer check failed");
`define STT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tokenizer check failed");
`else
`define STT_ASSERT_IMPL(lbl, ante, cons)
`define STT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/stt_pkg.sv]
// Types, codes and character classes of the source text tokenizer.
package stt_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_OP
    } scan_mode_t;

    typedef enum logic [2:0] {
        OPP_NONE,
        OPP_EQ,
        OPP_BANG,
        OPP_LT,
        OPP_GT,
        OPP_AMP,
        OPP_BAR
    } op_pend_t;

    typedef enum logic [4:0] {
        TK_EOF,
        TK_IF,
        TK_ELSE,
        TK_WHILE,
        TK_FOR,
        TK_INTEGRAL,
        TK_IDENT,
        TK_NUMBER,
        TK_OPERATOR,
        TK_ASSIGN,
        TK_LBRACE,
        TK_RBRACE,
        TK_LPAREN,
        TK_RPAREN,
        TK_SEMI,
        TK_LBRACKET,
        TK_RBRACKET,
        TK_COMMA,
        TK_UNKNOWN
    } tok_kind_t;

    localparam logic [3:0] OPC_NONE   = 4'd0;
    localparam logic [3:0] OPC_PLUS   = 4'd1;
    localparam logic [3:0] OPC_MINUS  = 4'd2;
    localparam logic [3:0] OPC_STAR   = 4'd3;
    localparam logic [3:0] OPC_SLASH  = 4'd4;
    localparam logic [3:0] OPC_ASSIGN = 4'd5;
    localparam logic [3:0] OPC_EQ     = 4'd6;
    localparam logic [3:0] OPC_NE     = 4'd7;
    localparam logic [3:0] OPC_LT     = 4'd8;
    localparam logic [3:0] OPC_LE     = 4'd9;
    localparam logic [3:0] OPC_GT     = 4'd10;
    localparam logic [3:0] OPC_GE     = 4'd11;
    localparam logic [3:0] OPC_AND    = 4'd12;
    localparam logic [3:0] OPC_OR     = 4'd13;

    // Keywords as packed byte strings, last character in the low byte.
    localparam logic [63:0] KW_IF       = 64'h6966;
    localparam logic [63:0] KW_ELSE     = 64'h656C7365;
    localparam logic [63:0] KW_WHILE    = 64'h7768696C65;
    localparam logic [63:0] KW_FOR      = 64'h666F72;
    localparam logic [63:0] KW_INTEGRAL = 64'h696E74656772616C;

    typedef struct packed {
        tok_kind_t   kind;
        logic [3:0]  opc;
        logic [15:0] start;
        logic [15:0] len;
    } token_t;

    // Up to three tokens caused by one byte; last_idx is count minus one.
    typedef struct packed {
        logic [1:0]       last_idx;
        token_t [2:0]     tok;
    } bundle_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] opc;
    } kind_opc_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] opc;
        op_pend_t   pend;
    } sym_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic tok_kind_t word_kind(input logic [63:0] w, input logic kwp);
        tok_kind_t k;
        k = TK_IDENT;
        if (kwp) begin
            if (w == KW_IF)             k = TK_IF;
            else if (w == KW_ELSE)      k = TK_ELSE;
            else if (w == KW_WHILE)     k = TK_WHILE;
            else if (w == KW_FOR)       k = TK_FOR;
            else if (w == KW_INTEGRAL)  k = TK_INTEGRAL;
        end
        return k;
    endfunction

    // A pending operator character that found no partner.
    function automatic kind_opc_t single_op(input op_pend_t p);
        kind_opc_t r;
        unique case (p)
            OPP_EQ:  r = '{kind: TK_ASSIGN,   opc: OPC_ASSIGN};
            OPP_LT:  r = '{kind: TK_OPERATOR, opc: OPC_LT};
            OPP_GT:  r = '{kind: TK_OPERATOR, opc: OPC_GT};
            default: r = '{kind: TK_UNKNOWN,  opc: OPC_NONE};
        endcase
        return r;
    endfunction

    // Class of a byte that starts neither a word nor a number.
    function automatic sym_t sym_class(input logic [7:0] c);
        sym_t s;
        s = '{kind: TK_UNKNOWN, opc: OPC_NONE, pend: OPP_NONE};
        unique case (c)
            "{":     s.kind = TK_LBRACE;
            "}":     s.kind = TK_RBRACE;
            "(":     s.kind = TK_LPAREN;
            ")":     s.kind = TK_RPAREN;
            ";":     s.kind = TK_SEMI;
            "[":     s.kind = TK_LBRACKET;
            "]":     s.kind = TK_RBRACKET;
            ",":     s.kind = TK_COMMA;
            "+":     s = '{kind: TK_OPERATOR, opc: OPC_PLUS,  pend: OPP_NONE};
            "-":     s = '{kind: TK_OPERATOR, opc: OPC_MINUS, pend: OPP_NONE};
            "*":     s = '{kind: TK_OPERATOR, opc: OPC_STAR,  pend: OPP_NONE};
            "/":     s = '{kind: TK_OPERATOR, opc: OPC_SLASH, pend: OPP_NONE};
            "=":     s.pend = OPP_EQ;
            "!":     s.pend = OPP_BANG;
            "<":     s.pend = OPP_LT;
            ">":     s.pend = OPP_GT;
            "&":     s.pend = OPP_AMP;
            "|":     s.pend = OPP_BAR;
            default: s.kind = TK_UNKNOWN;
        endcase
        return s;
    endfunction

endpackage

[design/stt_front.sv]
// Scanner front end: accepts bytes, keeps the token state, builds token bundles.
`include "source_text_tokenizer_unit_assert.svh"
module stt_front
    import stt_pkg::*;
#(
    parameter int OB = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       q_full,
    output logic       q_push,
    output bundle_t    q_data
);

    scan_mode_t     mode_reg, mode_next;
    op_pend_t       opp_reg, opp_next;
    logic [63:0]    wbuf_reg, wbuf_next;
    logic           kwp_reg, kwp_next;
    logic [OB-1:0]  cur_reg, cur_next;
    logic [OB-1:0]  pst_reg, pst_next;
    logic [OB-1:0]  plen_reg, plen_next;
    logic           tf_reg, tf_next;

    logic           acc;
    logic           close;
    logic           used;
    logic [3:0]     code;
    sym_t           sym;
    kind_opc_t      sop;
    logic [OB-1:0]  cur;
    token_t         a_tok, m_tok, e_tok;
    logic           a_v, m_v;
    logic [1:0]     cnt;

    function automatic logic [OB-1:0] sat_inc(input logic [OB-1:0] v);
        return (v == '1) ? v : v + OB'(1);
    endfunction

    function automatic logic [15:0] clip16(input logic [OB-1:0] v);
        logic [OB+15:0] w;
        w = {16'b0, v};
        return (w[OB+15:16] != '0) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic token_t mk(input tok_kind_t k, input logic [3:0] o,
                                  input logic [OB-1:0] st, input logic [OB-1:0] ln);
        token_t t;
        t.kind  = k;
        t.opc   = o;
        t.start = clip16(st);
        t.len   = clip16(ln);
        return t;
    endfunction

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;
    assign close    = (s_tdata == 8'd0) || s_tlast;

    always_comb begin
        // A finished text restarts from the reset state.
        mode_next = tf_reg ? MODE_IDLE : mode_reg;
        opp_next  = tf_reg ? OPP_NONE  : opp_reg;
        wbuf_next = tf_reg ? 64'd0     : wbuf_reg;
        kwp_next  = tf_reg ? 1'b1      : kwp_reg;
        cur       = tf_reg ? '0        : cur_reg;
        pst_next  = tf_reg ? '0        : pst_reg;
        plen_next = tf_reg ? '0        : plen_reg;
        tf_next   = 1'b0;
        used      = 1'b0;
        code      = OPC_NONE;
        a_v       = 1'b0;
        m_v       = 1'b0;
        a_tok     = '0;
        m_tok     = '0;
        sym       = sym_class(s_tdata);
        sop       = single_op(opp_next);

        // Extend or close the pending token.
        unique case (mode_next)
            MODE_IDENT: begin
                if (is_alpha(s_tdata) || is_digit(s_tdata) || s_tdata == "_") begin
                    if (plen_next >= OB'(8)) kwp_next = 1'b0;
                    wbuf_next = {wbuf_next[55:0], s_tdata};
                    plen_next = sat_inc(plen_next);
                    used      = 1'b1;
                end else begin
                    a_v   = 1'b1;
                    a_tok = mk(word_kind(wbuf_next, kwp_next), OPC_NONE, pst_next,
                               plen_next);
                    mode_next = MODE_IDLE;
                    opp_next  = OPP_NONE;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(s_tdata)) begin
                    plen_next = sat_inc(plen_next);
                    used      = 1'b1;
                end else begin
                    a_v       = 1'b1;
                    a_tok     = mk(TK_NUMBER, OPC_NONE, pst_next, plen_next);
                    mode_next = MODE_IDLE;
                    opp_next  = OPP_NONE;
                end
            end
            MODE_OP: begin
                priority if (s_tdata == "=") begin
                    unique case (opp_next)
                        OPP_EQ:   code = OPC_EQ;
                        OPP_BANG: code = OPC_NE;
                        OPP_LT:   code = OPC_LE;
                        OPP_GT:   code = OPC_GE;
                        default:  code = OPC_NONE;
                    endcase
                end else if (s_tdata == "&" && opp_next == OPP_AMP) begin
                    code = OPC_AND;
                end else if (s_tdata == "|" && opp_next == OPP_BAR) begin
                    code = OPC_OR;
                end else begin
                    code = OPC_NONE;
                end
                a_v = 1'b1;
                if (code != OPC_NONE) begin
                    a_tok = mk(TK_OPERATOR, code, pst_next, OB'(2));
                    used  = 1'b1;
                end else begin
                    a_tok = mk(sop.kind, sop.opc, pst_next, OB'(1));
                end
                mode_next = MODE_IDLE;
                opp_next  = OPP_NONE;
            end
            MODE_IDLE: begin
            end
        endcase

        // Start a token, or emit a one-byte token, with this byte.
        if (!used && s_tdata != 8'd0 && !is_space(s_tdata)) begin
            if (is_alpha(s_tdata) || s_tdata == "_") begin
                mode_next = MODE_IDENT;
                pst_next  = cur;
                plen_next = OB'(1);
                wbuf_next = {56'd0, s_tdata};
                kwp_next  = 1'b1;
            end else if (is_digit(s_tdata)) begin
                mode_next = MODE_NUMBER;
                pst_next  = cur;
                plen_next = OB'(1);
            end else if (sym.pend != OPP_NONE) begin
                mode_next = MODE_OP;
                opp_next  = sym.pend;
                pst_next  = cur;
                plen_next = OB'(1);
            end else begin
                m_v   = 1'b1;
                m_tok = mk(sym.kind, sym.opc, cur, OB'(1));
            end
        end

        // Close the text: flush what is pending, then end of file.
        e_tok = mk(TK_EOF, OPC_NONE, (s_tdata == 8'd0) ? cur : sat_inc(cur), '0);
        if (close) begin
            sop = single_op(opp_next);
            unique case (mode_next)
                MODE_IDENT: begin
                    m_v   = 1'b1;
                    m_tok = mk(word_kind(wbuf_next, kwp_next), OPC_NONE, pst_next,
                               plen_next);
                end
                MODE_NUMBER: begin
                    m_v   = 1'b1;
                    m_tok = mk(TK_NUMBER, OPC_NONE, pst_next, plen_next);
                end
                MODE_OP: begin
                    m_v   = 1'b1;
                    m_tok = mk(sop.kind, sop.opc, pst_next, OB'(1));
                end
                MODE_IDLE: begin
                end
            endcase
            mode_next = MODE_IDLE;
            opp_next  = OPP_NONE;
            tf_next   = 1'b1;
        end

        cur_next = sat_inc(cur);
    end

    // Pack the tokens in order into the bundle.
    always_comb begin
        q_data = '0;
        cnt    = 2'd0;
        if (a_v) begin
            q_data.tok[cnt] = a_tok;
            cnt             = cnt + 2'd1;
        end
        if (m_v) begin
            q_data.tok[cnt] = m_tok;
            cnt             = cnt + 2'd1;
        end
        if (close) begin
            q_data.tok[cnt] = e_tok;
            cnt             = cnt + 2'd1;
        end
        q_data.last_idx = cnt - 2'd1;
        q_push          = acc && (cnt != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            opp_reg  <= OPP_NONE;
            wbuf_reg <= 64'd0;
            kwp_reg  <= 1'b1;
            cur_reg  <= '0;
            pst_reg  <= '0;
            plen_reg <= '0;
            tf_reg   <= 1'b0;
        end else if (acc) begin
            mode_reg <= mode_next;
            opp_reg  <= opp_next;
            wbuf_reg <= wbuf_next;
            kwp_reg  <= kwp_next;
            cur_reg  <= cur_next;
            pst_reg  <= pst_next;
            plen_reg <= plen_next;
            tf_reg   <= tf_next;
        end
    end

    `STT_ASSERT_IMPL(a_close_pushes, acc && close, q_push)
    `STT_ASSERT_NEXT(a_close_marks_done, acc && close, tf_reg && mode_reg == MODE_IDLE)

endmodule

[design/stt_queue.sv]
// Short queue of token bundles between the scanner and the output stage.
`include "source_text_tokenizer_unit_assert.svh"
module stt_queue
    import stt_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output bundle_t head_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    bundle_t               slot_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_BITS'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop) count_next = count_reg + CNT_BITS'(1);
        else if (pop && !push) count_next = count_reg - CNT_BITS'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `STT_ASSERT_IMPL(a_no_push_full, push, !full)
    `STT_ASSERT_IMPL(a_no_pop_empty, pop, head_valid)

endmodule

[design/stt_back.sv]
// Output stage: walks each bundle and presents one token per cycle while m_tready is high.
`include "source_text_tokenizer_unit_assert.svh"
module stt_back
    import stt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  bundle_t     head_data,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [4:0]  m_tuser,
    output logic        m_tlast
);

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    token_t      tok_reg;
    logic        end_reg;
    logic        free;
    logic        take;
    logic        at_last;

    assign free    = !valid_reg || m_tready;
    assign take    = free && head_valid;
    assign at_last = (idx_reg == head_data.last_idx);
    assign pop     = take && at_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (take) begin
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            tok_reg <= head_data.tok[idx_reg];
            end_reg <= at_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, tok_reg.len, tok_reg.start, tok_reg.opc};
    assign m_tuser  = tok_reg.kind;
    assign m_tlast  = end_reg;

    `STT_ASSERT_IMPL(a_idx_in_bundle, head_valid, idx_reg <= head_data.last_idx)

endmodule

[design/source_text_tokenizer_unit.sv]
// Top level of the streaming source text tokenizer.
// Path: a token passes through the bundle queue and then the output register to m_*.
// Throughput: one byte per cycle while each byte gives at most one token and m_tready
// is high; a byte giving several tokens holds the single output register until they
// drain; the QUEUE_DEPTH-bundle queue absorbs such bursts before s_tready drops.
// Reset: synchronous aresetn clears scanner state, queue and output valid; no sweep.
module source_text_tokenizer_unit
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Source bytes in.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last byte of the text
    // Tokens out.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] operator_code, [19:4] token_start,
                                   // [35:20] token_length, [39:36] zero
    output logic [4:0]  m_tuser,   // [4:0] token_kind
    output logic        m_tlast    // run_end: last token caused by one byte
);

    // Front to queue: one bundle per byte that gives any token.
    logic    q_full;
    logic    q_push;
    bundle_t q_data;

    // Queue to back end.
    logic    head_valid;
    bundle_t head_data;
    logic    pop;

    // Classify each byte, advance the token state and build its bundle.
    stt_front #(
        .OB (OFFSET_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    // Hold bundles so the scanner keeps going while the output side stalls.
    stt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // Drain each bundle one token per cycle through the output register while m_tready is high.
    stt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
